// ===== hw/rtl/pcee_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcee_pkg
// Types, character codes and the byte mapping function shared by the
// pathname case escape encoder.
// ----------------------------------------------------------------------------
package pcee_pkg;

   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int MAX_BYTES   = 7;
   localparam int CHUNKS      = 3;

   localparam logic [11:0] MAX_LEN_RESET = 12'd256;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_CTL_HI = 8'h1F;
   localparam logic [7:0] CASE_OFS  = 8'h20;
   localparam logic [7:0] HEX_OFS   = 8'h57;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        end_of_path;
      logic        truncated;
      logic [11:0] out_length;
   } rsp_type;

   // One all-or-nothing group of output bytes; bytes[0] goes out first.
   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;
   } chunk_type;

   // One accepted item after the room check, as handed to the back end.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
      logic [11:0]               base;
      logic                      last;
      logic                      truncated;
   } entry_type;

   function automatic chunk_type mk_chunk1(input logic [7:0] a);
      chunk_type r;
      r       = '0;
      r.len   = 3'd1;
      r.bytes[0] = a;
      return r;
   endfunction

   function automatic chunk_type mk_chunk2(input logic [7:0] a, input logic [7:0] b);
      chunk_type r;
      r       = '0;
      r.len   = 3'd2;
      r.bytes[0] = a;
      r.bytes[1] = b;
      return r;
   endfunction

   // Map one byte to its output group.
   function automatic chunk_type map_byte(input logic [7:0] c, input logic start);
      chunk_type  r;
      logic [7:0] lo;
      r  = '0;
      lo = {4'h0, c[3:0]};
      if (start && (c == CH_BTICK || c == CH_TILDE)) begin
         r = mk_chunk2(CH_COLON, c);
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         r = mk_chunk2(CH_COLON, c);
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         r = mk_chunk1(c - CASE_OFS);
      end else if ((c != CH_NUL && c <= CH_CTL_HI) || c >= CH_DEL) begin
         r.len      = 3'd4;
         r.bytes[0] = CH_COLON;
         r.bytes[1] = CH_HASH;
         r.bytes[2] = CH_ZERO + {4'h0, c[7:4]};
         r.bytes[3] = (c[3:0] < 4'd10) ? (lo + CH_ZERO) : (lo + HEX_OFS);
      end else if (c == CH_COLON) begin
         r = mk_chunk2(CH_COLON, CH_COLON);
      end else if (c == CH_SPACE) begin
         r = mk_chunk2(CH_COLON, CH_UNDER);
      end else if (c == CH_BSLASH) begin
         r = mk_chunk2(CH_COLON, CH_BAR);
      end else begin
         r = mk_chunk1(c);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/pcee_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcee_front
// Classify each input byte, apply the room check and build a queue entry.
// ----------------------------------------------------------------------------
module pcee_front
   import pcee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req,
   input  logic [11:0] max_len,
   output logic        push,
   output entry_type   entry
);

   logic [11:0] emitted_ff, emitted_in;
   logic        start_ff, start_in;
   logic [1:0]  held_ff, held_in;
   logic        stopped_ff, stopped_in;

   chunk_type [CHUNKS-1:0] ch;
   logic                   start_nx;
   logic [1:0]             held_nx;
   logic [12:0]            cnt;
   logic                   stop;
   logic [2:0]             pos;
   logic [7:0][7:0]        arr;

   // Group the byte and any held dots into up to three chunks.
   always_comb begin
      ch       = '0;
      start_nx = start_ff;
      held_nx  = held_ff;
      if (!stopped_ff) begin
         priority if (held_ff == 2'd0) begin
            if (start_ff && req.in_byte == CH_DOT) begin
               if (req.last_byte) begin
                  ch[0]    = mk_chunk1(CH_DOT);
                  start_nx = 1'b0;
               end else begin
                  held_nx = 2'd1;
               end
            end else begin
               ch[0]    = map_byte(req.in_byte, start_ff);
               start_nx = (req.in_byte == CH_SLASH);
            end
         end else if (held_ff == 2'd1) begin
            held_nx = 2'd0;
            if (req.in_byte == CH_SLASH) begin
               ch[0]    = mk_chunk1(CH_DOT);
               ch[1]    = mk_chunk1(CH_SLASH);
               start_nx = 1'b1;
            end else if (req.in_byte == CH_DOT) begin
               if (req.last_byte) begin
                  ch[0]    = mk_chunk1(CH_DOT);
                  ch[1]    = mk_chunk1(CH_DOT);
                  start_nx = 1'b0;
               end else begin
                  held_nx = 2'd2;
               end
            end else begin
               ch[0]    = mk_chunk2(CH_COLON, CH_DOT);
               ch[1]    = map_byte(req.in_byte, 1'b0);
               start_nx = 1'b0;
            end
         end else begin
            // two dots held (a count of three behaves the same)
            held_nx = 2'd0;
            if (req.in_byte == CH_SLASH) begin
               ch[0] = mk_chunk1(CH_DOT);
               ch[1] = mk_chunk1(CH_DOT);
            end else begin
               ch[0] = mk_chunk2(CH_COLON, CH_DOT);
               ch[1] = mk_chunk1(CH_DOT);
            end
            ch[2]    = map_byte(req.in_byte, 1'b0);
            start_nx = (req.in_byte == CH_SLASH);
         end
      end
   end

   // Room check: emit each chunk whole or stop the path.
   always_comb begin
      cnt  = {1'b0, emitted_ff};
      stop = stopped_ff;
      pos  = '0;
      arr  = '0;
      for (int i = 0; i < CHUNKS; i++) begin
         if (!stop && ch[i].len != 3'd0) begin
            if (cnt + 13'(ch[i].len) > {1'b0, max_len}) begin
               stop = 1'b1;
            end else begin
               for (int j = 0; j < 4; j++) begin
                  if (3'(j) < ch[i].len) begin
                     arr[3'(pos + 3'(j))] = ch[i].bytes[j];
                  end
               end
               pos = pos + ch[i].len;
               cnt = cnt + 13'(ch[i].len);
            end
         end
      end
   end

   always_comb begin
      entry.bytes     = arr[MAX_BYTES-1:0];
      entry.count     = pos;
      entry.base      = emitted_ff;
      entry.last      = req.last_byte;
      entry.truncated = stop;
      push            = accept && (pos != 3'd0 || req.last_byte);
   end

   always_comb begin
      emitted_in = emitted_ff;
      start_in   = start_ff;
      held_in    = held_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         if (req.last_byte) begin
            emitted_in = '0;
            start_in   = 1'b1;
            held_in    = '0;
            stopped_in = 1'b0;
         end else begin
            emitted_in = cnt[11:0];
            start_in   = start_nx;
            held_in    = held_nx;
            stopped_in = stop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff <= '0;
         start_ff   <= 1'b1;
         held_ff    <= '0;
         stopped_ff <= 1'b0;
      end else begin
         emitted_ff <= emitted_in;
         start_ff   <= start_in;
         held_ff    <= held_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== hw/rtl/pcee_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcee_queue
// Short entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module pcee_queue
   import pcee_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head
);

   entry_type [QDEPTH-1:0] mem_ff;
   logic [QPTR_W-1:0]      wr_ff, wr_in;
   logic [QPTR_W-1:0]      rd_ff, rd_in;
   logic [QPTR_W:0]        cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full       = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/pcee_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcee_back
// Serialize queue entries into result items through an output register.
// ----------------------------------------------------------------------------
module pcee_back
   import pcee_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      deq,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load, done, bare;

   assign rsp_empty = !valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      load = head_valid && (!valid_ff || rsp_pop);
      bare = (head.count == 3'd0);
      done = bare || (idx_ff == head.count - 3'd1);
      deq  = load && done;

      rsp_in             = rsp_ff;
      rsp_in.out_byte    = bare ? CH_NUL : head.bytes[idx_ff];
      rsp_in.byte_valid  = !bare;
      rsp_in.end_of_path = head.last && done;
      rsp_in.truncated   = head.last && done && head.truncated;
      rsp_in.out_length  = bare ? head.base : head.base + {9'd0, idx_ff} + 12'd1;

      idx_in   = load ? (done ? 3'd0 : idx_ff + 3'd1) : idx_ff;
      valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/pathname_case_escape_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pathname_case_escape_encoder_core
// Path: an item's first result reaches rsp_ through the entry queue and then
// the output register, once the output register is free.
// Throughput: one item per cycle into the front while the queue is not full,
// one result per cycle out of the back while results are taken; 0-7 per item.
// Reset: synchronous; restores max_output_length to 256 and empties queues.
// ----------------------------------------------------------------------------
module pathname_case_escape_encoder_core
   import pcee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        push,
   output logic        full,
   input  req_type     req_data,
   // result item channel
   output logic        empty,
   input  logic        pop,
   output rsp_type     rsp_data,
   // configuration: max_output_length
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);

   logic [11:0] max_len_ff, max_len_in;
   logic        accept;
   logic        q_push, q_full, q_head_valid, q_pop;
   entry_type   q_in, q_head;

   // Take configuration writes at any time; the block is idle by contract.
   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // Hold off the input while the entry queue has no free slot.
   assign full   = q_full;
   assign accept = push && !q_full;

   // Front: classify the byte, update path state, build one entry.
   pcee_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .max_len (max_len_ff),
      .push    (q_push),
      .entry   (q_in)
   );

   // Decouple the front from the output drain.
   pcee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // Back: drain each entry one result item per cycle while results are taken.
   pcee_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .deq        (q_pop),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp        (rsp_data)
   );

endmodule

// ===== verif/pathname_case_escape_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pathname_case_escape_encoder_core_tb
// Self-checking bench for the pathname case escape encoder. A short table of
// directed pathnames is followed by random pathnames built from components
// ("." and ".." among them) under several output limits. Every accepted
// input item runs through a local encoder model, and each result popped from
// the block is compared field by field with the oldest predicted byte.
// ----------------------------------------------------------------------------
module pathname_case_escape_encoder_core_tb
   import pcee_pkg::*;
();

   localparam int CLK_HALF   = 6;
   localparam int RAND_ITEMS = 420;
   localparam int FLOOD_HOLD = 300;
   localparam int SETTLE     = 16;

   typedef enum logic [1:0] {ROW_PUSH, ROW_CHECK, ROW_LIMIT} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      req;
      rsp_type      want;
      logic [11:0]  limit;
   } row_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   req_type     req_data;
   logic        empty;
   logic        pop;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [11:0] csr_data;

   pathname_case_escape_encoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // ------------------------------------------------------------------------
   // Encoder model state: one pathname in flight plus the length limit.
   // ------------------------------------------------------------------------
   logic [11:0] lim_len;
   logic [11:0] out_count;
   bit          comp_start;
   logic [1:0]  dot_hold;
   bit          halted;

   rsp_type     item_out[$];     // bytes produced by the item being encoded
   rsp_type     encoded_q[$];    // encoded bytes still awaited from the block
   row_type     dir_rows[$];
   logic [7:0]  path_bytes[$];

   int          fault_count = 0;
   int          sent_n      = 0;
   bit          flood_ok    = 0;

   function automatic rsp_type mk_rsp(input logic [7:0] b, input logic v, input logic e,
                                      input logic t, input logic [11:0] len);
      rsp_type r;
      r.out_byte    = b;
      r.byte_valid  = v;
      r.end_of_path = e;
      r.truncated   = t;
      r.out_length  = len;
      return r;
   endfunction

   function automatic void clear_path();
      out_count  = '0;
      comp_start = 1'b1;
      dot_hold   = 2'd0;
      halted     = 1'b0;
   endfunction

   // Emit a group of n bytes all or nothing; once a group misses the limit,
   // drop everything else for this pathname.
   function automatic void emit_group(input int n, input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3);
      logic [3:0][7:0] grp;
      int i;
      grp = {b3, b2, b1, b0};
      if (halted) return;
      if (int'(out_count) + n > int'(lim_len)) begin
         halted = 1'b1;
         return;
      end
      for (i = 0; i < n; i++) begin
         out_count = out_count + 12'd1;
         item_out.push_back(mk_rsp(grp[i], 1'b1, 1'b0, 1'b0, out_count));
      end
   endfunction

   function automatic void escape_char(input logic [7:0] c, input bit start);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = CH_ZERO + {4'h0, c[7:4]};
      lo = (c[3:0] < 4'd10) ? CH_ZERO + {4'h0, c[3:0]} : HEX_OFS + {4'h0, c[3:0]};
      if (start && (c == CH_BTICK || c == CH_TILDE)) begin
         emit_group(2, CH_COLON, c, 8'h00, 8'h00);
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         emit_group(2, CH_COLON, c, 8'h00, 8'h00);
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         emit_group(1, c - CASE_OFS, 8'h00, 8'h00, 8'h00);
      end else if ((c != CH_NUL && c <= CH_CTL_HI) || c >= CH_DEL) begin
         emit_group(4, CH_COLON, CH_HASH, hi, lo);
      end else if (c == CH_COLON) begin
         emit_group(2, CH_COLON, CH_COLON, 8'h00, 8'h00);
      end else if (c == CH_SPACE) begin
         emit_group(2, CH_COLON, CH_UNDER, 8'h00, 8'h00);
      end else if (c == CH_BSLASH) begin
         emit_group(2, CH_COLON, CH_BAR, 8'h00, 8'h00);
      end else begin
         emit_group(1, c, 8'h00, 8'h00, 8'h00);
      end
      comp_start = (c == CH_SLASH);
   endfunction

   // Encode one input item into item_out. Leading dots wait in dot_hold
   // until the next byte tells a "." or ".." component from a dotted name.
   function automatic void encode_item(input req_type r);
      logic [7:0] c;
      rsp_type    tail;
      c = r.in_byte;
      item_out.delete();
      if (!halted) begin
         if (dot_hold == 2'd0) begin
            if (comp_start && c == CH_DOT) begin
               if (r.last_byte) begin
                  emit_group(1, CH_DOT, 8'h00, 8'h00, 8'h00);
                  comp_start = 1'b0;
               end else begin
                  dot_hold = 2'd1;
               end
            end else begin
               escape_char(c, comp_start);
            end
         end else if (dot_hold == 2'd1) begin
            dot_hold = 2'd0;
            if (c == CH_SLASH) begin
               emit_group(1, CH_DOT, 8'h00, 8'h00, 8'h00);
               escape_char(c, 1'b0);
            end else if (c == CH_DOT) begin
               if (r.last_byte) begin
                  emit_group(1, CH_DOT, 8'h00, 8'h00, 8'h00);
                  emit_group(1, CH_DOT, 8'h00, 8'h00, 8'h00);
                  comp_start = 1'b0;
               end else begin
                  dot_hold = 2'd2;
               end
            end else begin
               emit_group(2, CH_COLON, CH_DOT, 8'h00, 8'h00);
               escape_char(c, 1'b0);
            end
         end else begin
            // two dots held; a third hold count cannot occur and lands here too
            dot_hold = 2'd0;
            if (c == CH_SLASH) begin
               emit_group(1, CH_DOT, 8'h00, 8'h00, 8'h00);
               emit_group(1, CH_DOT, 8'h00, 8'h00, 8'h00);
            end else begin
               emit_group(2, CH_COLON, CH_DOT, 8'h00, 8'h00);
               emit_group(1, CH_DOT, 8'h00, 8'h00, 8'h00);
            end
            escape_char(c, 1'b0);
         end
      end
      if (r.last_byte) begin
         // close the pathname: flag the final byte, or send a bare end marker
         if (item_out.size() == 0) begin
            item_out.push_back(mk_rsp(8'h00, 1'b0, 1'b1, halted, out_count));
         end else begin
            tail             = item_out.pop_back();
            tail.end_of_path = 1'b1;
            tail.truncated   = halted;
            item_out.push_back(tail);
         end
         clear_path();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Gap before an item: random, with every third stretch of 48 items
   // running back to back.
   function automatic int pick_gap(input int n);
      if ((n / 48) % 3 == 1) return 0;
      return $urandom_range(0, 7);
   endfunction

   function automatic void add_row(input row_kind_type k, input logic [7:0] b, input logic l,
                                   input rsp_type w);
      row_type row;
      row.kind  = k;
      row.req   = '{in_byte: b, last_byte: l};
      row.want  = w;
      row.limit = {4'h0, b};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_limit(input logic [11:0] v);
      row_type row;
      row.kind  = ROW_LIMIT;
      row.req   = '0;
      row.want  = '0;
      row.limit = v;
      dir_rows.push_back(row);
   endfunction

   function automatic logic [7:0] rand_char();
      logic [7:0] ch;
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5, 15: ch = CH_LO_A + 8'($urandom_range(0, 25));
         6, 7:  ch = CH_UP_A + 8'($urandom_range(0, 25));
         8:     ch = CH_ZERO + 8'($urandom_range(0, 9));
         9: begin
            case ($urandom_range(0, 6))
               0:       ch = CH_COLON;
               1:       ch = CH_SPACE;
               2:       ch = CH_BSLASH;
               3:       ch = CH_BTICK;
               4:       ch = CH_TILDE;
               5:       ch = CH_NUL;
               default: ch = 8'h2D;   // '-'
            endcase
         end
         10:      ch = 8'($urandom_range(0, 255));
         11:      ch = 8'($urandom_range(1, 31));
         12:      ch = 8'($urandom_range(127, 255));
         13:      ch = CH_DOT;
         default: ch = CH_SLASH;
      endcase
      return ch;
   endfunction

   function automatic void add_name(input int n);
      int i;
      for (i = 0; i < n; i++) path_bytes.push_back(rand_char());
   endfunction

   // Build one pathname into path_bytes. Mostly well-formed components with
   // random names; now and then raw noise or one long name.
   function automatic void build_path();
      int ncomp;
      int i;
      path_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
         ncomp = $urandom_range(1, 8);
         for (i = 0; i < ncomp; i++) begin
            path_bytes.push_back(8'($urandom_range(0, 255)));
         end
         return;
      end
      if ($urandom_range(0, 24) == 0) begin
         add_name($urandom_range(40, 90));
         return;
      end
      ncomp = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) path_bytes.push_back(CH_SLASH);
      for (i = 0; i < ncomp; i++) begin
         case ($urandom_range(0, 9))
            0: path_bytes.push_back(CH_DOT);
            1: begin
               path_bytes.push_back(CH_DOT);
               path_bytes.push_back(CH_DOT);
            end
            2: begin
               path_bytes.push_back(CH_DOT);
               add_name($urandom_range(1, 4));
            end
            3: begin
               path_bytes.push_back(CH_DOT);
               path_bytes.push_back(CH_DOT);
               add_name($urandom_range(1, 3));
            end
            4: begin
               path_bytes.push_back($urandom_range(0, 1) ? CH_BTICK : CH_TILDE);
               add_name($urandom_range(0, 3));
            end
            5: add_name($urandom_range(1, 2));
            default: add_name($urandom_range(1, 6));
         endcase
         if (i < ncomp - 1 || $urandom_range(0, 5) == 0) path_bytes.push_back(CH_SLASH);
      end
   endfunction

   // Offer one item and hold it until taken; predict at the accepting edge.
   // Push is lowered only when a gap follows, so it never toggles in one step.
   task automatic send_item(input req_type r, input bit typed, input rsp_type want);
      int gap;
      gap = pick_gap(sent_n);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      push     <= 1'b1;
      do @(posedge clock); while (full);
      encode_item(r);
      if (typed) begin
         encoded_q.push_back(want);
      end else begin
         foreach (item_out[i]) encoded_q.push_back(item_out[i]);
      end
      sent_n++;
   endtask

   // Write the length limit only once every predicted byte has come back
   // and the block has had time to settle.
   task automatic write_limit(input logic [11:0] v);
      push <= 1'b0;
      while (encoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      lim_len = v;
   endtask

   function automatic void check_field(input string tag, input int want, input int got);
      if (want != got) begin
         fault_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
      end
   endfunction

   function automatic void check_result(input rsp_type got);
      rsp_type want;
      if (encoded_q.size() == 0) begin
         fault_count++;
         $display("%0t: unexpected result, expected nothing, got %h", $time, got);
         return;
      end
      want = encoded_q.pop_front();
      check_field("out_byte",    want.out_byte,    got.out_byte);
      check_field("byte_valid",  want.byte_valid,  got.byte_valid);
      check_field("end_of_path", want.end_of_path, got.end_of_path);
      check_field("truncated",   want.truncated,   got.truncated);
      check_field("out_length",  want.out_length,  got.out_length);
   endfunction

   // ------------------------------------------------------------------------
   // Clock and watchdog
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Stop the run with a failure if it never finishes.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side: pop with random stalls; hold off once for a long stretch
   // during the first random phase so the block fills and pushes back.
   // ------------------------------------------------------------------------
   initial begin : result_side
      int  wait_n;
      int  taken;
      bit  held;
      taken = 0;
      held  = 1'b0;
      pop <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         wait_n = pick_gap(taken);
         if (flood_ok && !held) begin
            wait_n = wait_n + FLOOD_HOLD;
            held   = 1'b1;
         end
         if (wait_n > 0) begin
            pop <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         check_result(rsp_data);
         taken++;
      end
   end

   // ------------------------------------------------------------------------
   // Input side: directed table, then random phases, then drain and report.
   // ------------------------------------------------------------------------
   initial begin : item_side
      int          phase;
      int          rand_sent;
      int          npaths;
      int          p;
      logic [11:0] lim;

      reset     <= 1'b1;
      push      <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      lim_len = MAX_LEN_RESET;
      clear_path();

      // Single-byte pathnames right after reset: expectations typed in.
      add_row(ROW_CHECK, CH_LO_A, 1'b1, mk_rsp(CH_UP_A, 1'b1, 1'b1, 1'b0, 12'd1));
      add_row(ROW_CHECK, CH_NUL,  1'b1, mk_rsp(CH_NUL,  1'b1, 1'b1, 1'b0, 12'd1));
      add_row(ROW_CHECK, CH_DOT,  1'b1, mk_rsp(CH_DOT,  1'b1, 1'b1, 1'b0, 12'd1));
      // Every escape kind; backtick and tilde at a component start.
      add_row(ROW_PUSH, CH_BTICK,  1'b0, '0);
      add_row(ROW_PUSH, CH_UP_A,   1'b0, '0);
      add_row(ROW_PUSH, CH_COLON,  1'b0, '0);
      add_row(ROW_PUSH, CH_SPACE,  1'b0, '0);
      add_row(ROW_PUSH, CH_BSLASH, 1'b0, '0);
      add_row(ROW_PUSH, 8'h01,     1'b0, '0);
      add_row(ROW_PUSH, CH_SLASH,  1'b0, '0);
      add_row(ROW_PUSH, CH_TILDE,  1'b0, '0);
      add_row(ROW_PUSH, CH_DEL,    1'b0, '0);
      add_row(ROW_PUSH, 8'hFF,     1'b1, '0);
      // "../", "./", a dotted name ".Z" and a double-dotted name "..q".
      add_row(ROW_PUSH, CH_DOT,   1'b0, '0);
      add_row(ROW_PUSH, CH_DOT,   1'b0, '0);
      add_row(ROW_PUSH, CH_SLASH, 1'b0, '0);
      add_row(ROW_PUSH, CH_DOT,   1'b0, '0);
      add_row(ROW_PUSH, CH_SLASH, 1'b0, '0);
      add_row(ROW_PUSH, CH_DOT,   1'b0, '0);
      add_row(ROW_PUSH, CH_UP_Z,  1'b0, '0);
      add_row(ROW_PUSH, CH_SLASH, 1'b0, '0);
      add_row(ROW_PUSH, CH_DOT,   1'b0, '0);
      add_row(ROW_PUSH, CH_DOT,   1'b0, '0);
      add_row(ROW_PUSH, 8'h71,    1'b1, '0);   // 'q'
      // Zero limit: the first byte stops output, only a truncated marker.
      add_limit(12'd0);
      add_row(ROW_CHECK, CH_LO_A, 1'b1, mk_rsp(8'h00, 1'b0, 1'b1, 1'b1, 12'd0));
      // Limit 1: an uppercase escape needs two bytes and must not fit.
      add_limit(12'd1);
      add_row(ROW_CHECK, CH_UP_A, 1'b1, mk_rsp(8'h00, 1'b0, 1'b1, 1'b1, 12'd0));
      // Limit 2: the escape fits exactly, the next byte truncates.
      add_limit(12'd2);
      add_row(ROW_PUSH,  CH_UP_A, 1'b0, '0);
      add_row(ROW_CHECK, 8'h62,   1'b1, mk_rsp(8'h00, 1'b0, 1'b1, 1'b1, 12'd2));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         case (dir_rows[i].kind)
            ROW_LIMIT: write_limit(dir_rows[i].limit);
            ROW_CHECK: send_item(dir_rows[i].req, 1'b1, dir_rows[i].want);
            default:   send_item(dir_rows[i].req, 1'b0, '0);
         endcase
      end

      // Random phases, each under its own limit. The first one runs at the
      // top limit and is where the result side holds off.
      phase     = 0;
      rand_sent = 0;
      while (rand_sent < RAND_ITEMS) begin
         if (phase == 0) begin
            lim = 12'hFFF;
         end else begin
            case ($urandom_range(0, 9))
               0:       lim = 12'd0;
               1:       lim = 12'($urandom_range(1, 3));
               2, 3:    lim = 12'($urandom_range(4, 20));
               4:       lim = 12'hFFF;
               5:       lim = 12'($urandom_range(21, 4094));
               default: lim = MAX_LEN_RESET;
            endcase
         end
         write_limit(lim);
         flood_ok = (phase == 0);
         npaths   = $urandom_range(3, 10);
         for (p = 0; p < npaths; p++) begin
            build_path();
            foreach (path_bytes[k]) begin
               send_item('{in_byte: path_bytes[k], last_byte: (k == path_bytes.size() - 1)},
                         1'b0, '0);
            end
            rand_sent += path_bytes.size();
         end
         flood_ok = 1'b0;
         phase++;
      end

      // Drain: wait for every predicted byte, then let the block settle.
      push <= 1'b0;
      while (encoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
